// File: src/cnsv_pkg.sv
// Shared types, constants and field layout for the cross neighborhood sorted vector block.
`timescale 1ns / 1ps

package cnsv_pkg;

	// Field widths.
	localparam int COORD_BITS = 12;
	localparam int CFG_BITS   = 13;
	localparam int VAL_BITS   = 8;
	localparam int SUM_BITS   = 11;
	localparam int NUM_LANES  = 5;
	localparam int CNT_BITS   = 3;
	localparam int RANK_BITS  = 3;

	// Stream payload widths (whole bytes).
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 56;

	// Reset values of the image size registers.
	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

	// Register indexes on the configuration port.
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// Reciprocals for the floor average: t/3 = (t*2731)>>13, t/5 = (t*3277)>>14,
	// exact for every sum the neighborhood can produce.
	localparam int PROD_BITS  = 23;
	localparam logic [11:0] RECIP3 = 12'd2731;
	localparam logic [11:0] RECIP5 = 12'd3277;

	// Which neighbor a lane checks.
	typedef enum logic [2:0] {
		DIR_CENTER,
		DIR_LEFT,
		DIR_RIGHT,
		DIR_UP,
		DIR_DOWN
	} lane_dir_t;

	typedef logic [NUM_LANES-1:0][VAL_BITS-1:0]  val_vec_t;
	typedef logic [NUM_LANES-1:0][RANK_BITS-1:0] rank_vec_t;

	// Per-stage load strobes of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_ld_t;

endpackage

// File: src/cnsv_lane.sv
// One neighbor lane: bounds check of its position and first pipeline register.
`timescale 1ns / 1ps

module cnsv_lane (
	input  logic                                clk,
	input  logic                                ld,
	input  cnsv_pkg::lane_dir_t                 dir,
	input  logic [cnsv_pkg::COORD_BITS-1:0]     pos_x,
	input  logic [cnsv_pkg::COORD_BITS-1:0]     pos_y,
	input  logic [cnsv_pkg::CFG_BITS-1:0]       image_width,
	input  logic [cnsv_pkg::CFG_BITS-1:0]       image_height,
	input  logic [cnsv_pkg::VAL_BITS-1:0]       value,
	output logic                                oob_s1,
	output logic [cnsv_pkg::VAL_BITS-1:0]       value_s1
);
	import cnsv_pkg::*;

	logic [COORD_BITS:0] px;
	logic [COORD_BITS:0] py;
	logic                wrap;
	logic                oob;

	// Neighbor position; x+1 and y+1 keep their carry, x-1 and y-1 at zero are flagged.
	always_comb begin
		px   = {1'b0, pos_x};
		py   = {1'b0, pos_y};
		wrap = 1'b0;
		unique case (dir)
			DIR_CENTER: begin
			end
			DIR_LEFT: begin
				px   = {1'b0, pos_x} - 1'b1;
				wrap = (pos_x == '0);
			end
			DIR_RIGHT: begin
				px = {1'b0, pos_x} + 1'b1;
			end
			DIR_UP: begin
				py   = {1'b0, pos_y} - 1'b1;
				wrap = (pos_y == '0);
			end
			DIR_DOWN: begin
				py = {1'b0, pos_y} + 1'b1;
			end
			default: begin
				wrap = 1'b1;
			end
		endcase
		oob = wrap || (px >= image_width) || (py >= image_height);
	end

	// Stage 1 register.
	always_ff @(posedge clk) begin
		if (ld) begin
			oob_s1   <= oob;
			value_s1 <= value;
		end
	end

endmodule

// File: src/cnsv_fill.sv
// Merge of the lane results: in-bounds sum and count, floor average, and fill.
`timescale 1ns / 1ps

module cnsv_fill (
	input  logic                              clk,
	input  cnsv_pkg::pipe_ld_t                ld,
	input  cnsv_pkg::val_vec_t                vals_s1,
	input  logic [cnsv_pkg::NUM_LANES-1:0]    oob_s1,
	output cnsv_pkg::val_vec_t                vals_s4,
	output logic [cnsv_pkg::SUM_BITS-1:0]     sum_s4
);
	import cnsv_pkg::*;

	logic [SUM_BITS-1:0]  total;
	logic [CNT_BITS-1:0]  count;
	logic [SUM_BITS-1:0]  total_s2;
	logic [CNT_BITS-1:0]  count_s2;
	val_vec_t             vals_s2;
	logic [NUM_LANES-1:0] oob_s2;
	logic [PROD_BITS-1:0] prod3;
	logic [PROD_BITS-1:0] prod5;
	logic [VAL_BITS-1:0]  avg;
	logic [VAL_BITS-1:0]  avg_s3;
	val_vec_t             vals_s3;
	logic [NUM_LANES-1:0] oob_s3;
	val_vec_t             filled;
	logic [SUM_BITS-1:0]  filled_sum;

	// Sum and count of the in-bounds values.
	always_comb begin
		total = '0;
		count = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (!oob_s1[i]) begin
				total = total + SUM_BITS'(vals_s1[i]);
				count = count + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			total_s2 <= total;
			count_s2 <= count;
			vals_s2  <= vals_s1;
			oob_s2   <= oob_s1;
		end
	end

	// Floor average by the count; no in-bounds value gives zero.
	always_comb begin
		prod3 = PROD_BITS'(total_s2) * PROD_BITS'(RECIP3);
		prod5 = PROD_BITS'(total_s2) * PROD_BITS'(RECIP5);
		case (count_s2)
			3'd1:    avg = total_s2[VAL_BITS-1:0];
			3'd2:    avg = total_s2[VAL_BITS:1];
			3'd3:    avg = prod3[VAL_BITS+12:13];
			3'd4:    avg = total_s2[VAL_BITS+1:2];
			3'd5:    avg = prod5[VAL_BITS+13:14];
			default: avg = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			avg_s3  <= avg;
			vals_s3 <= vals_s2;
			oob_s3  <= oob_s2;
		end
	end

	// Replace every out-of-bounds value by the average and sum the result.
	always_comb begin
		filled_sum = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			filled[i]  = oob_s3[i] ? avg_s3 : vals_s3[i];
			filled_sum = filled_sum + SUM_BITS'(filled[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			vals_s4 <= filled;
			sum_s4  <= filled_sum;
		end
	end

endmodule

// File: src/cnsv_sort.sv
// Descending sort of the five filled values by rank counting, then placement.
`timescale 1ns / 1ps

module cnsv_sort (
	input  logic                              clk,
	input  cnsv_pkg::pipe_ld_t                ld,
	input  cnsv_pkg::val_vec_t                vals_s4,
	input  logic [cnsv_pkg::SUM_BITS-1:0]     sum_s4,
	output cnsv_pkg::val_vec_t                sorted_s6,
	output logic [cnsv_pkg::SUM_BITS-1:0]     sum_s6
);
	import cnsv_pkg::*;

	rank_vec_t           rank;
	rank_vec_t           rank_s5;
	val_vec_t            vals_s5;
	logic [SUM_BITS-1:0] sum_s5;
	val_vec_t            placed;

	// Rank of each value: larger values go first, equal values keep their lane order.
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			rank[i] = '0;
			for (int j = 0; j < NUM_LANES; j++) begin
				if ((j != i) && ((vals_s4[j] > vals_s4[i]) ||
				    ((j < i) && (vals_s4[j] == vals_s4[i])))) begin
					rank[i] = rank[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			rank_s5 <= rank;
			vals_s5 <= vals_s4;
			sum_s5  <= sum_s4;
		end
	end

	// Each output slot takes the value whose rank matches it.
	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			placed[k] = '0;
			for (int i = 0; i < NUM_LANES; i++) begin
				if (rank_s5[i] == RANK_BITS'(k)) begin
					placed[k] = vals_s5[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			sorted_s6 <= placed;
			sum_s6    <= sum_s5;
		end
	end

endmodule

// File: src/cross_neighborhood_sorted_vector.sv
// Top level of the cross neighborhood sorted vector block.
//
//  Channel  | Direction | Payload
//  ---------+-----------+---------------------------------------------------------
//  s_axis   | in        | pos_x, pos_y, center, left, right, up, down values
//  m_axis   | out       | five values sorted largest first, and their sum
//  cfg      | in        | write of image_width (index 0) or image_height (index 1)
//
// One request is taken every cycle while the output is not stalled; its result is
// offered at the end of the six-stage pipeline (lane check, sum, average, fill,
// rank, place).
// Every stage has its own valid bit, so a stalled output only stops the stages
// behind it once they are full; bubbles are squeezed out meanwhile.
// Reset clears the valid bits and loads 640 by 480 into the size registers.
`timescale 1ns / 1ps

module cross_neighborhood_sorted_vector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pos_x[11:0], pos_y[23:12], center_value[31:24], left_value[39:32],
	// right_value[47:40], up_value[55:48], down_value[63:56]
	input  logic [cnsv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// Output stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// sorted_first[7:0], sorted_second[15:8], sorted_third[23:16],
	// sorted_fourth[31:24], sorted_fifth[39:32], vector_sum[50:40], zero[55:51]
	output logic [cnsv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// Configuration write port.
	input  logic                                 cfg_wr_en,
	input  logic                                 cfg_index,
	input  logic [cnsv_pkg::CFG_BITS-1:0]        cfg_data
);
	import cnsv_pkg::*;

	logic [CFG_BITS-1:0]   width_q;
	logic [CFG_BITS-1:0]   height_q;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	val_vec_t              in_vals;
	val_vec_t              vals_s1;
	logic [NUM_LANES-1:0]  oob_s1;
	val_vec_t              vals_s4;
	logic [SUM_BITS-1:0]   sum_s4;
	val_vec_t              sorted_s6;
	logic [SUM_BITS-1:0]   sum_s6;
	logic [6:1]            valid_q;
	logic [6:1]            rdy;
	pipe_ld_t              ld;
	lane_dir_t             lane_dir [NUM_LANES];

	// Image size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	// Unpack the input request.
	assign pos_x      = s_axis_tdata[11:0];
	assign pos_y      = s_axis_tdata[23:12];
	assign in_vals[0] = s_axis_tdata[31:24];
	assign in_vals[1] = s_axis_tdata[39:32];
	assign in_vals[2] = s_axis_tdata[47:40];
	assign in_vals[3] = s_axis_tdata[55:48];
	assign in_vals[4] = s_axis_tdata[63:56];

	// A stage moves on when it is empty or the stage after it moves on.
	always_comb begin
		rdy[6] = !valid_q[6] || m_axis_tready;
		for (int k = 5; k >= 1; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		ld.s1 = s_axis_tvalid && rdy[1];
		ld.s2 = valid_q[1] && rdy[2];
		ld.s3 = valid_q[2] && rdy[3];
		ld.s4 = valid_q[3] && rdy[4];
		ld.s5 = valid_q[4] && rdy[5];
		ld.s6 = valid_q[5] && rdy[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[1]) valid_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= 6; k++) begin
				if (rdy[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	assign s_axis_tready = rdy[1];

	// One lane for each neighbor.
	assign lane_dir[0] = DIR_CENTER;
	assign lane_dir[1] = DIR_LEFT;
	assign lane_dir[2] = DIR_RIGHT;
	assign lane_dir[3] = DIR_UP;
	assign lane_dir[4] = DIR_DOWN;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		cnsv_lane u_lane (
			.clk          (clk),
			.ld           (ld.s1),
			.dir          (lane_dir[g]),
			.pos_x        (pos_x),
			.pos_y        (pos_y),
			.image_width  (width_q),
			.image_height (height_q),
			.value        (in_vals[g]),
			.oob_s1       (oob_s1[g]),
			.value_s1     (vals_s1[g])
		);
	end

	cnsv_fill u_fill (
		.clk     (clk),
		.ld      (ld),
		.vals_s1 (vals_s1),
		.oob_s1  (oob_s1),
		.vals_s4 (vals_s4),
		.sum_s4  (sum_s4)
	);

	cnsv_sort u_sort (
		.clk       (clk),
		.ld        (ld),
		.vals_s4   (vals_s4),
		.sum_s4    (sum_s4),
		.sorted_s6 (sorted_s6),
		.sum_s6    (sum_s6)
	);

	// Pack the result.
	assign m_axis_tvalid = valid_q[6];
	assign m_axis_tdata  = {5'b0, sum_s6, sorted_s6[4], sorted_s6[3], sorted_s6[2],
	                        sorted_s6[1], sorted_s6[0]};

endmodule

// File: src/cnsv_checker.sv
// Port-level checks of the cross neighborhood sorted vector block, bound to the top level.
`timescale 1ns / 1ps

module cnsv_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [cnsv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import cnsv_pkg::*;

	logic [SUM_BITS-1:0] sum_chk;

	// Sum of the five output values as the result shows them.
	assign sum_chk = SUM_BITS'(m_axis_tdata[7:0]) + SUM_BITS'(m_axis_tdata[15:8]) +
	                 SUM_BITS'(m_axis_tdata[23:16]) + SUM_BITS'(m_axis_tdata[31:24]) +
	                 SUM_BITS'(m_axis_tdata[39:32]);

	// The reported sum matches the five sorted values.
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[50:40] == sum_chk))
		else $error("vector_sum does not match the sorted values");

	// The values leave in descending order.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[7:0] >= m_axis_tdata[15:8]) &&
		                   (m_axis_tdata[15:8] >= m_axis_tdata[23:16]) &&
		                   (m_axis_tdata[23:16] >= m_axis_tdata[31:24]) &&
		                   (m_axis_tdata[31:24] >= m_axis_tdata[39:32])))
		else $error("sorted values out of order");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	// No result is offered in the first cycle after reset is released.
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result offered right after reset");

endmodule

bind cross_neighborhood_sorted_vector cnsv_checker u_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the cross neighborhood sorted vector block.
`timescale 1ns / 1ps

module testbench;
	import cnsv_pkg::*;

	// One neighborhood request as it travels on s_axis_tdata, pos_x in the lowest bits.
	typedef struct packed {
		logic [VAL_BITS-1:0]   down_v;
		logic [VAL_BITS-1:0]   up_v;
		logic [VAL_BITS-1:0]   right_v;
		logic [VAL_BITS-1:0]   left_v;
		logic [VAL_BITS-1:0]   center_v;
		logic [COORD_BITS-1:0] pos_y;
		logic [COORD_BITS-1:0] pos_x;
	} nbhd_req_t;

	// One ranked result as it travels on m_axis_tdata, largest value in the lowest bits.
	typedef struct packed {
		logic [4:0]          pad;
		logic [SUM_BITS-1:0] total;
		logic [VAL_BITS-1:0] fifth;
		logic [VAL_BITS-1:0] fourth;
		logic [VAL_BITS-1:0] third;
		logic [VAL_BITS-1:0] second;
		logic [VAL_BITS-1:0] first;
	} ranked_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic                   cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_BITS-1:0]    cfg_data = '0;

	// Image size as the block should currently see it.
	logic [CFG_BITS-1:0] img_w = WIDTH_RESET;
	logic [CFG_BITS-1:0] img_h = HEIGHT_RESET;

	nbhd_req_t pend_q[$];
	ranked_t   ranked_q[$];
	nbhd_req_t cur_req;
	int        n_issued = 0;
	int        n_done = 0;
	int        n_errors = 0;
	int        send_gap = 0;
	int        stall_left = 0;
	bit        tx_calm = 1'b0;
	bit        rx_calm = 1'b0;

	cross_neighborhood_sorted_vector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// A position is inside when both coordinates are below the size, at full precision.
	function automatic bit in_image(int px, int py);
		return px < int'(img_w) && py < int'(img_h);
	endfunction

	// Fill out-of-image lanes with the floor average of the others, then rank descending.
	function automatic ranked_t rank_neighborhood(nbhd_req_t r);
		int      x;
		int      y;
		int      sum_in;
		int      n_in;
		int      avg;
		int      t;
		int      v[NUM_LANES];
		bit      off[NUM_LANES];
		ranked_t res;
		x = r.pos_x;
		y = r.pos_y;
		v[DIR_CENTER] = r.center_v;
		v[DIR_LEFT]   = r.left_v;
		v[DIR_RIGHT]  = r.right_v;
		v[DIR_UP]     = r.up_v;
		v[DIR_DOWN]   = r.down_v;
		// Column or row zero has no left or upper neighbor.
		off[DIR_CENTER] = !in_image(x, y);
		off[DIR_LEFT]   = (x == 0) || !in_image(x - 1, y);
		off[DIR_RIGHT]  = !in_image(x + 1, y);
		off[DIR_UP]     = (y == 0) || !in_image(x, y - 1);
		off[DIR_DOWN]   = !in_image(x, y + 1);
		sum_in = 0;
		n_in = 0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (!off[i]) begin
				sum_in += v[i];
				n_in++;
			end
		end
		// With no lane inside, the fill value is zero.
		avg = (n_in != 0) ? sum_in / n_in : 0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (off[i])
				v[i] = avg;
		end
		for (int i = 0; i < NUM_LANES - 1; i++) begin
			for (int j = 0; j < NUM_LANES - 1 - i; j++) begin
				if (v[j] < v[j + 1]) begin
					t = v[j];
					v[j] = v[j + 1];
					v[j + 1] = t;
				end
			end
		end
		res.first  = VAL_BITS'(v[0]);
		res.second = VAL_BITS'(v[1]);
		res.third  = VAL_BITS'(v[2]);
		res.fourth = VAL_BITS'(v[3]);
		res.fifth  = VAL_BITS'(v[4]);
		res.total  = SUM_BITS'(v[0] + v[1] + v[2] + v[3] + v[4]);
		res.pad    = '0;
		return res;
	endfunction

	// Wait cycles before the next request or result; calm stretches have none.
	function automatic int draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("mismatch in %0s at result %0d: got %0d, expected %0d", what, n_done, got,
			want);
	endtask

	// Request driver: presents queued requests and records the expected ranking on acceptance.
	always @(posedge clk) begin : drive_requests
		logic give;
		give = 1'b0;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				ranked_q.push_back(rank_neighborhood(cur_req));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
				end else if (pend_q.size() != 0) begin
					give = 1'b1;
					cur_req = pend_q.pop_front();
					s_axis_tdata <= cur_req;
					if ($urandom_range(0, 31) == 0)
						tx_calm = ~tx_calm;
					send_gap <= draw_wait(tx_calm);
				end
				s_axis_tvalid <= give;
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin : check_results
		ranked_t got;
		ranked_t want;
		int      left_n;
		left_n = stall_left;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (ranked_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = ranked_q.pop_front();
					if (got.first !== want.first)
						report_mismatch("sorted_first", got.first, want.first);
					if (got.second !== want.second)
						report_mismatch("sorted_second", got.second, want.second);
					if (got.third !== want.third)
						report_mismatch("sorted_third", got.third, want.third);
					if (got.fourth !== want.fourth)
						report_mismatch("sorted_fourth", got.fourth, want.fourth);
					if (got.fifth !== want.fifth)
						report_mismatch("sorted_fifth", got.fifth, want.fifth);
					if (got.total !== want.total)
						report_mismatch("vector_sum", got.total, want.total);
					if (got.pad !== want.pad)
						report_mismatch("padding", got.pad, want.pad);
				end
				n_done++;
				if ($urandom_range(0, 31) == 0)
					rx_calm = ~rx_calm;
				left_n = draw_wait(rx_calm);
			end
			if (left_n != 0) begin
				m_axis_tready <= 1'b0;
				stall_left <= left_n - 1;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	task automatic add_req(input int x, input int y, input int c, input int l, input int r,
		input int u, input int d);
		nbhd_req_t q;
		q.pos_x = COORD_BITS'(x);
		q.pos_y = COORD_BITS'(y);
		q.center_v = VAL_BITS'(c);
		q.left_v = VAL_BITS'(l);
		q.right_v = VAL_BITS'(r);
		q.up_v = VAL_BITS'(u);
		q.down_v = VAL_BITS'(d);
		pend_q.push_back(q);
		n_issued++;
	endtask

	// Coordinates cluster around the image edges, where the lanes change state.
	function automatic int pick_coord(int lim);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return (lim - 1) & 12'hFFF;
			3: return lim & 12'hFFF;
			4: return (lim - 2) & 12'hFFF;
			5: return (lim > 0) ? $urandom_range(0, (lim > 4096 ? 4096 : lim) - 1) : 0;
			6: return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic int pick_value(int style, int base);
		case (style)
			0: return $urandom_range(0, 1) ? 255 : 0;
			1: return base;
			2: return (base + $urandom_range(0, 3)) & 8'hFF;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic add_random(input int count);
		int style;
		int base;
		for (int k = 0; k < count; k++) begin
			style = $urandom_range(0, 4);
			base = $urandom_range(0, 255);
			add_req(pick_coord(img_w), pick_coord(img_h), pick_value(style, base),
				pick_value(style, base), pick_value(style, base), pick_value(style, base),
				pick_value(style, base));
		end
	endtask

	// Size registers change only with the pipeline empty.
	task automatic write_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		img_w = w;
		img_h = h;
	endtask

	task automatic drain;
		do
			@(posedge clk);
		while (n_done < n_issued);
	endtask

	initial begin : stimulus
		int phase_w[12] = '{1, 4096, 0, 5, 8191, 2, 4097, 1, 4096, 0, 0, 640};
		int phase_h[12] = '{1, 4096, 37, 0, 8191, 3, 1, 4096, 2, 0, 0, 480};
		phase_w[9] = $urandom_range(1, 4096);
		phase_h[9] = $urandom_range(1, 4096);
		phase_w[10] = $urandom_range(1, 64);
		phase_h[10] = $urandom_range(1, 64);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset size of 640 by 480.
		add_req(0, 0, 17, 200, 90, 3, 45);
		add_req(639, 479, 250, 1, 128, 77, 9);
		add_req(639, 0, 10, 20, 30, 40, 50);
		add_req(0, 479, 60, 70, 80, 90, 100);
		add_req(320, 240, 255, 255, 255, 255, 255);
		add_req(320, 240, 0, 0, 0, 0, 0);
		add_req(640, 100, 11, 222, 33, 44, 55);
		add_req(4095, 4095, 255, 255, 255, 255, 255);
		add_req(100, 480, 5, 6, 7, 199, 9);
		add_req(0, 0, 1, 255, 1, 255, 0);
		add_req(200, 200, 10, 200, 30, 255, 0);
		add_req(5, 5, 5, 7, 5, 7, 5);
		add_req(641, 0, 100, 100, 100, 100, 100);
		add_req(1, 1, 8, 250, 16, 240, 32);
		add_req(638, 478, 255, 0, 255, 0, 255);
		add_req(12'hAAA, 12'h555, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
		add_req(12'h155, 12'h0AA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
		add_req(639, 1, 255, 255, 0, 255, 254);
		add_req(0, 240, 254, 0, 255, 253, 255);
		add_req(4095, 0, 1, 2, 3, 4, 5);
		add_random(40);
		drain();

		// Random part over a range of image sizes, extremes included.
		for (int p = 0; p < 12; p++) begin
			write_size(CFG_BITS'(phase_w[p]), CFG_BITS'(phase_h[p]));
			add_random(50);
			drain();
		end

		repeat (20) @(posedge clk);
		if (ranked_q.size() != 0)
			report_mismatch("missing results", 0, ranked_q.size());
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
